### rtl/assert_macros.svh
// assertion macros used by the packed bit field reader module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define PBFR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define PBFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pbfr_pkg.sv
// constants and register codes of the packed bit field reader
`default_nettype none

package pbfr_pkg;

	localparam int STORE_BYTES    = 256;
	localparam int ADDR_W         = $clog2(STORE_BYTES);
	localparam int MAX_FIELD_BITS = 63;
	localparam int WIDTH_W        = 6;
	localparam int COUNT_W        = 9;
	localparam int INDEX_W        = 11;
	localparam int START_W        = INDEX_W + WIDTH_W;
	localparam int BADDR_W        = START_W - 3;
	localparam int SPAN_BYTES     = 9;
	localparam int WIN_W          = 8 * SPAN_BYTES;
	localparam int SHIFT_W        = 7;
	localparam int SPAN_CNT_W     = 4;
	localparam int PADDR_W        = 4;
	localparam int PDATA_W        = 32;

	localparam logic [1:0] REG_FIELD_WIDTH = 2'd0;
	localparam logic [1:0] REG_BIT_ORDER   = 2'd1;
	localparam logic [1:0] REG_BYTE_COUNT  = 2'd2;

	localparam logic               CMD_LOAD = 1'b0;
	localparam logic               CMD_READ = 1'b1;
	localparam logic               ORDER_LSB_FIRST = 1'b1;

	localparam logic [WIDTH_W-1:0] FIELD_WIDTH_RST = 6'd8;
	localparam logic               BIT_ORDER_RST   = 1'b0;
	localparam logic [COUNT_W-1:0] BYTE_COUNT_RST  = 9'd256;

endpackage

`default_nettype wire

### rtl/packed_bit_field_reader.sv
// Packed bit field reader: a 256-byte store filled by loads, read back as fields of
// field_width bits packed back to back, MSB-first or LSB-first within each byte.
// A load is written into the store in the cycle it is accepted. A read fetches nine bytes,
// the most a 63-bit field at any bit offset can touch, one per cycle through the single
// port of the store; the read pipeline then drains in ST_XT and the result is formed in
// ST_OUT. No new word is accepted until the read has returned to ST_IDLE.
// A finished result waits in the output register while loads keep being accepted.
`default_nettype none

`include "assert_macros.svh"

module packed_bit_field_reader (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire                                   command,
	input  wire  [pbfr_pkg::ADDR_W-1:0]           byte_address,
	input  wire  [7:0]                            byte_value,
	input  wire  [pbfr_pkg::INDEX_W-1:0]          field_index,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic [pbfr_pkg::MAX_FIELD_BITS-1:0]   field_value,
	output logic                                  in_range,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [pbfr_pkg::PADDR_W-1:0]          paddr,
	input  wire  [pbfr_pkg::PDATA_W-1:0]          pwdata,
	output logic [pbfr_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready
);

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_XT, ST_OUT} state_t;

	localparam logic [pbfr_pkg::SPAN_CNT_W-1:0] LAST_BYTE =
		pbfr_pkg::SPAN_CNT_W'(pbfr_pkg::SPAN_BYTES - 1);

	// configuration
	logic [pbfr_pkg::WIDTH_W-1:0] field_width_q;
	logic                         bit_order_q;
	logic [pbfr_pkg::COUNT_W-1:0] byte_count_q;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q <= pbfr_pkg::FIELD_WIDTH_RST;
			bit_order_q   <= pbfr_pkg::BIT_ORDER_RST;
			byte_count_q  <= pbfr_pkg::BYTE_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				pbfr_pkg::REG_FIELD_WIDTH: field_width_q <= pwdata[pbfr_pkg::WIDTH_W-1:0];
				pbfr_pkg::REG_BIT_ORDER:   bit_order_q   <= pwdata[0];
				pbfr_pkg::REG_BYTE_COUNT:  byte_count_q  <= pwdata[pbfr_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pbfr_pkg::REG_FIELD_WIDTH: prdata = pbfr_pkg::PDATA_W'(field_width_q);
			pbfr_pkg::REG_BIT_ORDER:   prdata = pbfr_pkg::PDATA_W'(bit_order_q);
			pbfr_pkg::REG_BYTE_COUNT:  prdata = pbfr_pkg::PDATA_W'(byte_count_q);
			default:                   prdata = '0;
		endcase
	end

	// datapath signals
	state_t                           state_q;
	logic [pbfr_pkg::SPAN_CNT_W-1:0]  cnt_q;
	logic [pbfr_pkg::BADDR_W-1:0]     addr_q;
	logic [pbfr_pkg::SHIFT_W-1:0]     sh_q;
	logic [pbfr_pkg::WIDTH_W-1:0]     w_q;
	logic                             lsb_q;
	logic                             range_q;
	logic [pbfr_pkg::WIN_W-1:0]       acc_q;
	logic                             out_valid_q;
	logic [pbfr_pkg::MAX_FIELD_BITS-1:0] field_value_q;
	logic                             in_range_q;

	logic                             rd_vld_s1;
	logic                             rd_zero_s1;
	logic [7:0]                       rd_data_s1;

	logic [7:0]                       byte_store [pbfr_pkg::STORE_BYTES];

	logic                             accept;
	logic                             mem_we;
	logic                             mem_re;
	logic [pbfr_pkg::COUNT_W-1:0]     len;
	logic [pbfr_pkg::START_W-1:0]     start;
	logic [pbfr_pkg::SHIFT_W-1:0]     sh_msb;
	logic [7:0]                       rd_byte;
	logic [pbfr_pkg::WIN_W-1:0]       win;
	logic [pbfr_pkg::MAX_FIELD_BITS-1:0] mask;
	logic [pbfr_pkg::MAX_FIELD_BITS-1:0] extracted;
	logic                             out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign mem_we    = accept && (command == pbfr_pkg::CMD_LOAD);
	assign mem_re    = (state_q == ST_RD);
	assign out_free  = !out_valid_q || !out_stall;

	assign len = (byte_count_q > pbfr_pkg::COUNT_W'(pbfr_pkg::STORE_BYTES)) ?
		pbfr_pkg::COUNT_W'(pbfr_pkg::STORE_BYTES) : byte_count_q;
	assign start = pbfr_pkg::START_W'(field_index) * pbfr_pkg::START_W'(field_width_q);
	// msb-first window holds the first byte on top, field sits above the trailing bits
	assign sh_msb = pbfr_pkg::SHIFT_W'(pbfr_pkg::WIN_W) - pbfr_pkg::SHIFT_W'(start[2:0])
		- pbfr_pkg::SHIFT_W'(field_width_q);

	assign rd_byte   = rd_zero_s1 ? 8'd0 : rd_data_s1;
	assign win       = acc_q >> sh_q;
	assign mask      = ~({pbfr_pkg::MAX_FIELD_BITS{1'b1}} << w_q);
	assign extracted = range_q ? (win[pbfr_pkg::MAX_FIELD_BITS-1:0] & mask) : '0;

	// byte store, one port: writes only while idle, reads only while fetching
	always_ff @(posedge clk) begin
		if (mem_we) begin
			byte_store[byte_address] <= byte_value;
		end
		if (mem_re) begin
			rd_data_s1 <= byte_store[addr_q[pbfr_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (rd_vld_s1) begin
				if (lsb_q) begin
					acc_q <= {rd_byte, acc_q[pbfr_pkg::WIN_W-1:8]};
				end else begin
					acc_q <= {acc_q[pbfr_pkg::WIN_W-9:0], rd_byte};
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && command == pbfr_pkg::CMD_READ) begin
						state_q <= ST_RD;
						cnt_q   <= '0;
						addr_q  <= start[pbfr_pkg::START_W-1:3];
						w_q     <= field_width_q;
						lsb_q   <= (bit_order_q == pbfr_pkg::ORDER_LSB_FIRST);
						sh_q    <= (bit_order_q == pbfr_pkg::ORDER_LSB_FIRST) ?
							pbfr_pkg::SHIFT_W'(start[2:0]) : sh_msb;
						range_q <= pbfr_pkg::START_W'({len, 3'b000}) > start;
					end
				end
				ST_RD: begin
					rd_zero_s1 <= pbfr_pkg::BADDR_W'(len) <= addr_q;
					addr_q     <= addr_q + 1'b1;
					cnt_q      <= cnt_q + 1'b1;
					if (cnt_q == LAST_BYTE) begin
						state_q <= ST_XT;
					end
				end
				ST_XT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						field_value_q <= extracted;
						in_range_q    <= range_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign field_value = field_value_q;
	assign in_range    = in_range_q;

	`PBFR_ASSERT_IMPL(a_oor_zero, out_valid && !in_range, field_value == '0,
		"out-of-range word carries a nonzero field")
	`PBFR_ASSERT_NEXT(a_read_starts, accept && command == pbfr_pkg::CMD_READ,
		state_q == ST_RD && cnt_q == '0, "read word did not start a byte fetch")
	`PBFR_ASSERT_NEXT(a_fetch_ends, state_q == ST_RD && cnt_q == LAST_BYTE,
		state_q == ST_XT && rd_vld_s1, "byte fetch did not end after nine reads")
	`PBFR_ASSERT_IMPL(a_result_src, $rose(out_valid), $past(state_q) == ST_OUT,
		"result word appeared outside the result state")
	`PBFR_ASSERT_IMPL(a_no_write_busy, mem_we, state_q == ST_IDLE && !rd_vld_s1,
		"store written while a fetch is in flight")

endmodule

`default_nettype wire

### dv/tb.sv
// self-checking testbench for the packed bit field reader
module tb;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES = 16;
	localparam logic ORDER_MSB_FIRST = 1'b0;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [pbfr_pkg::MAX_FIELD_BITS-1:0] value;
		logic                                in_range;
	} field_result_t;

	typedef struct {
		logic [pbfr_pkg::WIDTH_W-1:0]        width;
		logic                                order;
		logic [pbfr_pkg::COUNT_W-1:0]        count;
		logic                                cmd;
		logic [pbfr_pkg::ADDR_W-1:0]         addr;
		logic [7:0]                          data;
		logic [pbfr_pkg::INDEX_W-1:0]        idx;
		bit                                  typed;
		logic [pbfr_pkg::MAX_FIELD_BITS-1:0] value;
		logic                                in_range;
	} dir_row_t;

	typedef struct {
		logic [pbfr_pkg::WIDTH_W-1:0] width;
		logic                         order;
		logic [pbfr_pkg::COUNT_W-1:0] count;
		idle_mode_t                   mode;
		int                           words;
	} phase_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic                                command = pbfr_pkg::CMD_LOAD;
	logic [pbfr_pkg::ADDR_W-1:0]         byte_address = '0;
	logic [7:0]                          byte_value = '0;
	logic [pbfr_pkg::INDEX_W-1:0]        field_index = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [pbfr_pkg::MAX_FIELD_BITS-1:0] field_value;
	logic                                in_range;
	logic                                psel = 1'b0;
	logic                                penable = 1'b0;
	logic                                pwrite = 1'b0;
	logic [pbfr_pkg::PADDR_W-1:0]        paddr = '0;
	logic [pbfr_pkg::PDATA_W-1:0]        pwdata = '0;
	logic [pbfr_pkg::PDATA_W-1:0]        prdata;
	logic                                pready;

	logic [7:0]                   byte_image [pbfr_pkg::STORE_BYTES];
	logic [pbfr_pkg::WIDTH_W-1:0] cur_width = pbfr_pkg::FIELD_WIDTH_RST;
	logic                         cur_order = pbfr_pkg::BIT_ORDER_RST;
	logic [pbfr_pkg::COUNT_W-1:0] cur_count = pbfr_pkg::BYTE_COUNT_RST;
	field_result_t                pending_fields [$];
	int                           mismatches = 0;
	int                           cycles = 0;
	int                           send_idle_pct = 0;
	int                           stall_pct = 0;

	// store bytes 0, 1, 254 and 255 are loaded here before any row reads them
	dir_row_t dir_rows [24] = '{
		'{6'd8,  ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_LOAD, 8'd0,   8'hA5, 11'd0,
			1'b0, 63'd0,   1'b0},
		'{6'd8,  ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_LOAD, 8'd1,   8'h3C, 11'd2047,
			1'b0, 63'd0,   1'b0},
		'{6'd8,  ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_LOAD, 8'd255, 8'hFF, 11'd0,
			1'b0, 63'd0,   1'b0},
		'{6'd8,  ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_LOAD, 8'd254, 8'h00, 11'd0,
			1'b0, 63'd0,   1'b0},
		'{6'd8,  ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd0,
			1'b1, 63'hA5,  1'b1},
		'{6'd8,  ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd1,
			1'b1, 63'h3C,  1'b1},
		'{6'd8,  ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd255,
			1'b1, 63'hFF,  1'b1},
		'{6'd8,  ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd256,
			1'b1, 63'd0,   1'b0},
		'{6'd4,  ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd0,
			1'b1, 63'hA,   1'b1},
		'{6'd4,  ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd1,
			1'b1, 63'h5,   1'b1},
		'{6'd4,  pbfr_pkg::ORDER_LSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0, 8'h00, 11'd0,
			1'b1, 63'h5,   1'b1},
		'{6'd4,  pbfr_pkg::ORDER_LSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0, 8'h00, 11'd1,
			1'b1, 63'hA,   1'b1},
		'{6'd1,  pbfr_pkg::ORDER_LSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0, 8'h00, 11'd0,
			1'b1, 63'd1,   1'b1},
		'{6'd1,  ORDER_MSB_FIRST, 9'd511, pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd2047,
			1'b1, 63'd1,   1'b1},
		'{6'd1,  ORDER_MSB_FIRST, 9'd511, pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd2039,
			1'b1, 63'd0,   1'b1},
		'{6'd12, ORDER_MSB_FIRST, 9'd2,   pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd1,
			1'b1, 63'hC00, 1'b1},
		'{6'd12, pbfr_pkg::ORDER_LSB_FIRST, 9'd2, pbfr_pkg::CMD_READ, 8'd0, 8'h00, 11'd1,
			1'b1, 63'h3,   1'b1},
		'{6'd8,  ORDER_MSB_FIRST, 9'd1,   pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd1,
			1'b1, 63'd0,   1'b0},
		'{6'd63, ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd0,
			1'b0, 63'd0,   1'b0},
		'{6'd63, pbfr_pkg::ORDER_LSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0, 8'h00, 11'd32,
			1'b0, 63'd0,   1'b0},
		'{6'd63, pbfr_pkg::ORDER_LSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0, 8'h00, 11'd2047,
			1'b1, 63'd0,   1'b0},
		'{6'd0,  ORDER_MSB_FIRST, 9'd256, pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd2047,
			1'b1, 63'd0,   1'b1},
		'{6'd31, pbfr_pkg::ORDER_LSB_FIRST, 9'd0, pbfr_pkg::CMD_READ, 8'd0, 8'h00, 11'd0,
			1'b1, 63'd0,   1'b0},
		'{6'd63, ORDER_MSB_FIRST, 9'd200, pbfr_pkg::CMD_READ, 8'd0,   8'h00, 11'd25,
			1'b0, 63'd0,   1'b0}
	};

	phase_t phases [8] = '{
		'{6'd8,  ORDER_MSB_FIRST,           9'd256, IDLE_NONE,     200},
		'{6'd63, pbfr_pkg::ORDER_LSB_FIRST, 9'd256, IDLE_SENDER,   200},
		'{6'd1,  ORDER_MSB_FIRST,           9'd256, IDLE_RECEIVER, 200},
		'{6'd13, pbfr_pkg::ORDER_LSB_FIRST, 9'd100, IDLE_BOTH,     200},
		'{6'd63, ORDER_MSB_FIRST,           9'd1,   IDLE_NONE,     150},
		'{6'd5,  pbfr_pkg::ORDER_LSB_FIRST, 9'd511, IDLE_RECEIVER, 150},
		'{6'd0,  ORDER_MSB_FIRST,           9'd256, IDLE_SENDER,   100},
		'{6'd31, pbfr_pkg::ORDER_LSB_FIRST, 9'd0,   IDLE_BOTH,     100}
	};

	packed_bit_field_reader uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.byte_address (byte_address),
		.byte_value   (byte_value),
		.field_index  (field_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.field_value  (field_value),
		.in_range     (in_range),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic field_result_t extract_field(input logic [pbfr_pkg::INDEX_W-1:0] idx);
		int unsigned span;
		int unsigned len;
		int unsigned start;
		int unsigned pos;
		logic [pbfr_pkg::MAX_FIELD_BITS-1:0] acc;
		logic b;
		field_result_t r;
		span = int'(cur_width);
		len = (int'(cur_count) < pbfr_pkg::STORE_BYTES) ? int'(cur_count) :
			pbfr_pkg::STORE_BYTES;
		start = int'(idx) * span;
		acc = '0;
		r = '0;
		if (start >= len * 8)
			return r;
		for (int k = 0; k < span; k++) begin
			pos = start + k;
			b = 1'b0;
			// bytes past the valid length read as zero
			if ((pos >> 3) < len)
				b = byte_image[pos >> 3][(cur_order == pbfr_pkg::ORDER_LSB_FIRST) ?
					pos % 8 : 7 - pos % 8];
			if (cur_order == pbfr_pkg::ORDER_LSB_FIRST)
				acc[k] = b;
			else
				acc = {acc[pbfr_pkg::MAX_FIELD_BITS-2:0], b};
		end
		r.value = acc;
		r.in_range = 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
	endtask

	always @(posedge clk) begin
		field_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fields.size() == 0) begin
				report_mismatch("word with no read pending", 64'(field_value), 64'd0);
			end else begin
				want = pending_fields.pop_front();
				if (field_value !== want.value)
					report_mismatch("field_value", 64'(field_value), 64'(want.value));
				if (in_range !== want.in_range)
					report_mismatch("in_range", 64'(in_range), 64'(want.in_range));
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_word(input logic cmd, input logic [pbfr_pkg::ADDR_W-1:0] addr,
			input logic [7:0] data, input logic [pbfr_pkg::INDEX_W-1:0] idx, input bit typed,
			input field_result_t typed_result);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		byte_address <= addr;
		byte_value <= data;
		field_index <= idx;
		do @(posedge clk); while (in_stall);
		if (cmd == pbfr_pkg::CMD_LOAD)
			byte_image[addr] = data;
		else
			pending_fields.push_back(typed ? typed_result : extract_field(idx));
	endtask

	// loads give no result, so let a possible read finish before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_fields.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] code,
			input logic [pbfr_pkg::PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {code, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [pbfr_pkg::WIDTH_W-1:0] width, input logic order,
			input logic [pbfr_pkg::COUNT_W-1:0] count);
		settle();
		write_reg(pbfr_pkg::REG_FIELD_WIDTH, pbfr_pkg::PDATA_W'(width));
		write_reg(pbfr_pkg::REG_BIT_ORDER, pbfr_pkg::PDATA_W'(order));
		write_reg(pbfr_pkg::REG_BYTE_COUNT, pbfr_pkg::PDATA_W'(count));
		cur_width = width;
		cur_order = order;
		cur_count = count;
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 75;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct = 75;
			end
			default: begin
				send_idle_pct = 16;
				stall_pct = 16;
			end
		endcase
	endtask

	task automatic random_words(input int n);
		int unsigned len;
		int unsigned nfields;
		logic [pbfr_pkg::INDEX_W-1:0] idx;
		logic cmd;
		for (int i = 0; i < n; i++) begin
			len = (int'(cur_count) < pbfr_pkg::STORE_BYTES) ? int'(cur_count) :
				pbfr_pkg::STORE_BYTES;
			cmd = ($urandom_range(99) < 35) ? pbfr_pkg::CMD_LOAD : pbfr_pkg::CMD_READ;
			idx = pbfr_pkg::INDEX_W'($urandom_range(2 ** pbfr_pkg::INDEX_W - 1));
			// mostly aim at fields that start inside the valid bytes
			if (cur_width != 0 && len != 0 && $urandom_range(3) != 0) begin
				nfields = (len * 8 + int'(cur_width) - 1) / int'(cur_width);
				if (nfields > 2 ** pbfr_pkg::INDEX_W)
					nfields = 2 ** pbfr_pkg::INDEX_W;
				idx = pbfr_pkg::INDEX_W'($urandom_range(nfields - 1));
			end
			send_word(cmd, pbfr_pkg::ADDR_W'($urandom_range(255)), 8'($urandom_range(255)),
				idx, 1'b0, '0);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle(IDLE_NONE);

		// fill the whole store first, so no read ever sees an unwritten byte
		for (int a = 0; a < pbfr_pkg::STORE_BYTES; a++)
			send_word(pbfr_pkg::CMD_LOAD, pbfr_pkg::ADDR_W'(a), 8'($urandom_range(255)),
				pbfr_pkg::INDEX_W'($urandom_range(2 ** pbfr_pkg::INDEX_W - 1)), 1'b0, '0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].width != cur_width || dir_rows[i].order != cur_order ||
					dir_rows[i].count != cur_count)
				configure(dir_rows[i].width, dir_rows[i].order, dir_rows[i].count);
			send_word(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].idx,
				dir_rows[i].typed, '{dir_rows[i].value, dir_rows[i].in_range});
		end

		foreach (phases[i]) begin
			configure(phases[i].width, phases[i].order, phases[i].count);
			set_idle(phases[i].mode);
			random_words(phases[i].words);
		end

		for (int r = 0; r < 3; r++) begin
			configure(pbfr_pkg::WIDTH_W'($urandom_range(63)), 1'($urandom_range(1)),
				pbfr_pkg::COUNT_W'($urandom_range(1, pbfr_pkg::STORE_BYTES)));
			set_idle(idle_mode_t'(r + 1));
			random_words(50);
		end

		settle();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### packed_bit_field_reader.f
+incdir+rtl
rtl/pbfr_pkg.sv
rtl/packed_bit_field_reader.sv
dv/tb.sv
